// File: rtl/core/crcfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte update for the frame receiver.
// Used by crcfr_ctrl and crc_checked_frame_receiver_unit; depends on nothing.
package crcfr_pkg;

  // Field widths of the request and result channels.
  localparam int REQ_W    = 2;
  localparam int DATA_W   = 8;
  localparam int IDX_W    = 9;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 32;
  localparam int FLEN_W   = 10;
  localparam int WORD_W   = 32;

  // Frame layout and defaults.
  localparam int BUFFER_BYTES_DEF = 512;
  localparam int HEADER_BYTES     = 12;
  localparam int CRC_START        = 8;
  localparam int LEN_BYTES        = 4;
  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 8'd3;
  localparam logic [WORD_W-1:0] CRC_POLY      = 32'hEDB88320;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_BYTE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_CRC_BAD = 3'd2,
    ST_SHORT   = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_READ    = 3'd5
  } status_t;

  // Result of one request, as handed from the control logic to the output register.
  typedef struct packed {
    status_t           status;
    logic [CMD_W-1:0]  cmd;
    logic [FLEN_W-1:0] flen;
    logic              rd_valid;
  } res_t;

  // Reflected CRC-32 update by one byte, LSB first.
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [DATA_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {{(WORD_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < DATA_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/crcfr_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; contents are undefined until written.
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/crcfr_ctrl.sv
`timescale 1ns / 1ps
// Frame state, CRC update and completion check for the frame receiver.
// Uses crcfr_pkg; drives the address and write side of the frame buffer RAM.
module crcfr_ctrl
  import crcfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [DATA_W-1:0] rx_byte,
  input  logic [IDX_W-1:0]  read_index,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_data,
  output res_t              res,
  output logic              mem_we,
  output logic              mem_re,
  output logic [AW-1:0]     mem_addr,
  output logic [DATA_W-1:0] mem_wdata
);

  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam logic [FW-1:0]     FILL_FULL = FW'(BUFFER_BYTES);
  localparam logic [WORD_W-1:0] DEPTH_W32 = WORD_W'(BUFFER_BYTES);

  logic [FW-1:0]     fill_r,    fill_nxt;
  logic [DATA_W-1:0] idle_r,    idle_nxt;
  logic [WORD_W-1:0] crc_r,     crc_nxt;
  logic [WORD_W-1:0] decl_r,    decl_nxt;
  logic [WORD_W-1:0] rxcrc_r,   rxcrc_nxt;
  logic [CMD_W-1:0]  cmd_r,     cmd_nxt;
  logic [DATA_W-1:0] timeout_r, timeout_nxt;

  logic [DATA_W-1:0] idle_inc;
  logic [AW+IDX_W-1:0] idx_wide;
  logic [AW-1:0]     idx_addr;
  logic              idx_in_range;
  logic [4:0]        lane;

  // Read index mapped onto the buffer address space.
  assign idx_wide     = {{AW{1'b0}}, read_index};
  assign idx_addr     = idx_wide[AW-1:0];
  assign idx_in_range = ({{(WORD_W-IDX_W){1'b0}}, read_index} < DEPTH_W32);
  assign lane         = {fill_r[1:0], 3'b000};
  assign idle_inc     = idle_r + 8'd1;

  // Next state and result for the request accepted this cycle.
  always_comb begin
    fill_nxt    = fill_r;
    idle_nxt    = idle_r;
    crc_nxt     = crc_r;
    decl_nxt    = decl_r;
    rxcrc_nxt   = rxcrc_r;
    cmd_nxt     = cmd_r;
    timeout_nxt = cfg_we ? cfg_data : timeout_r;
    res         = '{status: ST_BYTE, cmd: '0, flen: '0, rd_valid: 1'b0};
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = fill_r[AW-1:0];
    mem_wdata   = rx_byte;

    if (accept) begin
      case (req_t'(req_type))
        REQ_BYTE: begin
          idle_nxt = '0;
          // Store the byte and fold it into the header fields or the CRC.
          if (fill_r < FILL_FULL) begin
            mem_we = 1'b1;
            if (fill_r < FW'(LEN_BYTES)) begin
              decl_nxt[lane +: DATA_W] = rx_byte;
            end else if (fill_r < FW'(CRC_START)) begin
              rxcrc_nxt[lane +: DATA_W] = rx_byte;
            end else begin
              crc_nxt = crc_byte(crc_r, rx_byte);
              if (fill_r < FW'(HEADER_BYTES)) begin
                cmd_nxt[lane +: DATA_W] = rx_byte;
              end
            end
            fill_nxt = fill_r + 1'b1;
          end
          // Frame complete once the header and the declared length are in.
          if (fill_nxt >= FW'(HEADER_BYTES) && WORD_W'(fill_nxt) >= decl_nxt) begin
            res.cmd  = cmd_nxt;
            res.flen = decl_nxt[FLEN_W-1:0];
            if (decl_nxt < WORD_W'(HEADER_BYTES)) begin
              res.status = ST_SHORT;
            end else if (~crc_nxt == rxcrc_nxt) begin
              res.status = ST_ACCEPT;
            end else begin
              res.status = ST_CRC_BAD;
            end
            fill_nxt = '0;
            crc_nxt  = '1;
          end
        end
        REQ_TICK: begin
          // Idle timeout discards any partial frame.
          if (idle_inc >= timeout_r) begin
            fill_nxt   = '0;
            crc_nxt    = '1;
            idle_nxt   = '0;
            res.status = ST_TIMEOUT;
          end else begin
            idle_nxt = idle_inc;
          end
        end
        REQ_READ: begin
          res.status   = ST_READ;
          res.rd_valid = idx_in_range;
          mem_re       = 1'b1;
          mem_addr     = idx_addr;
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      idle_r    <= '0;
      crc_r     <= '1;
      decl_r    <= '0;
      rxcrc_r   <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      fill_r    <= fill_nxt;
      idle_r    <= idle_nxt;
      crc_r     <= crc_nxt;
      decl_r    <= decl_nxt;
      rxcrc_r   <= rxcrc_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  // Command word is always rewritten before a frame can complete.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// File: rtl/core/crc_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Length-prefixed frame receiver with CRC-32 check and a byte-wide frame buffer.
// A result appears in the cycle after its request is accepted (output register).
// Throughput: one request per cycle unless stalled; at most one RAM access per request.
// Reset (synchronous, rst_n low): empty fill, idle count zero, timeout 3, output empty.
// Buffer contents are not cleared by reset and are undefined until written.
module crc_checked_frame_receiver_unit
  import crcfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]   in_rx_byte,
  input  logic [IDX_W-1:0]    in_read_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [CMD_W-1:0]    out_command_code,
  output logic [FLEN_W-1:0]   out_frame_length,
  output logic [DATA_W-1:0]   out_read_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic              accept;
  res_t              res;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  // Handshake: a new request enters whenever the output register is free or draining.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  crcfr_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .rx_byte   (in_rx_byte),
    .read_index(in_read_index),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  crcfr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(BUFFER_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Output register valid flag.
  assign out_valid_nxt = accept ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload; read data comes straight from the RAM's read register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_command_code = out_res_r.cmd;
  assign out_frame_length = out_res_r.flen;
  assign out_read_data    = out_res_r.rd_valid ? mem_rdata : '0;

  // Every accepted request yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
    else $error("accepted request produced no result");

  // Read data is nonzero only on read results.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ) |-> (out_read_data == '0))
    else $error("read data on a non-read result");

  // Command and length are only reported on frame completion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ACCEPT && out_status != ST_CRC_BAD &&
     out_status != ST_SHORT) |-> (out_command_code == '0 && out_frame_length == '0))
    else $error("frame fields on a non-completion result");

  // A stalled result is replaced only after it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule

// File: tb/sv/crcfr_result_checker.sv
`timescale 1ns / 1ps
// Holds the CRC-32 helper package shared with the stimulus and the result checker.
// The checker predicts every result of the frame receiver and compares it on the wire.
// Depends on crcfr_pkg for field widths, request kinds and status codes.
package crcfr_tb_pkg;
  import crcfr_pkg::*;

  // Reflected CRC-32 update, one input bit at a time.
  function automatic logic [WORD_W-1:0] crc32_step(input logic [WORD_W-1:0] crc,
                                                   input logic [DATA_W-1:0] data);
    logic [WORD_W-1:0] acc;
    logic              fb;
    acc = crc;
    for (int k = 0; k < DATA_W; k++) begin
      fb  = acc[0] ^ data[k];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

module crcfr_result_checker
  import crcfr_pkg::*;
  import crcfr_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]   in_rx_byte,
  input  logic [IDX_W-1:0]    in_read_index,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [CMD_W-1:0]    out_command_code,
  input  logic [FLEN_W-1:0]   out_frame_length,
  input  logic [DATA_W-1:0]   out_read_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [DATA_W-1:0]   cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  written_span,
  output int                  results_checked,
  output int                  accepted_frames,
  output int                  crc_rejects,
  output int                  short_frames,
  output int                  idle_discards,
  output int                  buffer_reads
);

  // One predicted result, laid out like the result channel.
  typedef struct packed {
    status_t           status;
    logic [CMD_W-1:0]  cmd;
    logic [FLEN_W-1:0] flen;
    logic [DATA_W-1:0] rdata;
  } outcome_t;

  // Predictor state: a private copy of the receiver's buffer, counters and register.
  logic [DATA_W-1:0] frame_mem [BUFFER_BYTES_DEF];
  int unsigned       fill;
  logic [DATA_W-1:0] idle_ticks;
  logic [DATA_W-1:0] idle_limit;
  logic [WORD_W-1:0] crc_acc;
  logic [WORD_W-1:0] decl_len;
  logic [WORD_W-1:0] rx_crc;
  outcome_t          outcomes_due [$];
  outcome_t          due;

  // Applies one request to the predictor state and returns the result it causes.
  function automatic outcome_t frame_rx_outcome(input logic [REQ_W-1:0]  kind,
                                                input logic [DATA_W-1:0] data,
                                                input logic [IDX_W-1:0]  idx);
    outcome_t o;
    o        = '0;
    o.status = ST_BYTE;
    case (kind)
      REQ_BYTE: begin
        idle_ticks = '0;
        // Bytes past a full buffer are neither stored nor hashed.
        if (fill < BUFFER_BYTES_DEF) begin
          frame_mem[fill] = data;
          if (fill < LEN_BYTES) begin
            decl_len[8*fill +: 8] = data;
          end else if (fill < CRC_START) begin
            rx_crc[8*(fill-LEN_BYTES) +: 8] = data;
          end else begin
            crc_acc = crc32_step(crc_acc, data);
          end
          fill++;
          if (fill > written_span) begin
            written_span = fill;
          end
        end
        // The frame is done once the header and the declared length are in.
        if (fill >= HEADER_BYTES && fill >= decl_len) begin
          o.cmd  = {frame_mem[CRC_START+3], frame_mem[CRC_START+2],
                    frame_mem[CRC_START+1], frame_mem[CRC_START]};
          o.flen = decl_len[FLEN_W-1:0];
          if (decl_len < HEADER_BYTES) begin
            o.status = ST_SHORT;
          end else if (~crc_acc == rx_crc) begin
            o.status = ST_ACCEPT;
          end else begin
            o.status = ST_CRC_BAD;
          end
          fill    = 0;
          crc_acc = '1;
        end
      end
      REQ_TICK: begin
        idle_ticks = idle_ticks + 8'd1;
        if (idle_ticks >= idle_limit) begin
          fill       = 0;
          crc_acc    = '1;
          idle_ticks = '0;
          o.status   = ST_TIMEOUT;
        end
      end
      REQ_READ: begin
        o.status = ST_READ;
        if (idx < BUFFER_BYTES_DEF) begin
          o.rdata = frame_mem[idx];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  // Register writes, accepted requests and accepted results, all sampled at the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill            = 0;
      idle_ticks      = '0;
      idle_limit      = TIMEOUT_RESET;
      crc_acc         = '1;
      decl_len        = '0;
      rx_crc          = '0;
      outcomes_due.delete();
      fail_count      = 0;
      written_span    = 0;
      results_checked = 0;
      accepted_frames = 0;
      crc_rejects     = 0;
      short_frames    = 0;
      idle_discards   = 0;
      buffer_reads    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        outcomes_due.push_back(frame_rx_outcome(in_req_type, in_rx_byte, in_read_index));
      end
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          note_failure($sformatf("result with no request waiting: status %0d cmd %h len %0d data %h",
                                 out_status, out_command_code, out_frame_length, out_read_data));
        end else begin
          due = outcomes_due.pop_front();
          results_checked++;
          if (out_status !== due.status || out_command_code !== due.cmd ||
              out_frame_length !== due.flen || out_read_data !== due.rdata) begin
            note_failure($sformatf({"result %0d: expected status %0d cmd %h len %0d data %h,",
                                    " got status %0d cmd %h len %0d data %h"},
                                   results_checked, due.status, due.cmd, due.flen, due.rdata,
                                   out_status, out_command_code, out_frame_length,
                                   out_read_data));
          end
          case (due.status)
            ST_ACCEPT:  accepted_frames++;
            ST_CRC_BAD: crc_rejects++;
            ST_SHORT:   short_frames++;
            ST_TIMEOUT: idle_discards++;
            ST_READ:    buffer_reads++;
            default: begin
            end
          endcase
        end
      end
    end
    pending = outcomes_due.size();
  end

endmodule

// File: tb/sv/tb_crc_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Top of the frame receiver testbench: clock, reset, request and register stimulus.
// Depends on crcfr_pkg, crcfr_tb_pkg and crcfr_result_checker, which judges results.
module tb_crc_checked_frame_receiver_unit;
  import crcfr_pkg::*;
  import crcfr_tb_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int LONG_HOLD    = 300;
  localparam int ITEM_GOAL    = 1950;
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type;
  logic [DATA_W-1:0]   in_rx_byte;
  logic [IDX_W-1:0]    in_read_index;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [CMD_W-1:0]    out_command_code;
  logic [FLEN_W-1:0]   out_frame_length;
  logic [DATA_W-1:0]   out_read_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [DATA_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int written_span;
  int results_checked;
  int accepted_frames;
  int crc_rejects;
  int short_frames;
  int idle_discards;
  int buffer_reads;

  // Stimulus bookkeeping: current timeout, idle ticks since the last byte, requests sent.
  int cur_timeout = TIMEOUT_RESET;
  int idle_seen   = 0;
  int items_sent  = 0;
  int timeout_plan [5];
  int phase_end [5];
  bit gap_on;
  bit stall_on;
  bit filler_on;
  bit hold_now;

  always #(HALF_PERIOD) clk = ~clk;

  crc_checked_frame_receiver_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command_code (out_command_code),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  crcfr_result_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command_code (out_command_code),
    .out_frame_length (out_frame_length),
    .out_read_data    (out_read_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .written_span     (written_span),
    .results_checked  (results_checked),
    .accepted_frames  (accepted_frames),
    .crc_rejects      (crc_rejects),
    .short_frames     (short_frames),
    .idle_discards    (idle_discards),
    .buffer_reads     (buffer_reads)
  );

  // Offers one request, with an occasional gap first, and returns at the accepting edge.
  task automatic send_request(input logic [REQ_W-1:0]  kind,
                              input logic [DATA_W-1:0] data,
                              input logic [IDX_W-1:0]  idx);
    if (gap_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_rx_byte    <= data;
    in_read_index <= idx;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
    // Track the idle count so that ticks inside a frame never discard it.
    if (kind == REQ_BYTE) begin
      idle_seen = 0;
    end else if (kind == REQ_TICK) begin
      idle_seen = (idle_seen + 1) % 256;
      if (idle_seen >= cur_timeout) begin
        idle_seen = 0;
      end
    end
  endtask

  // Reads back a buffer entry that has been written at least once.
  task automatic send_read();
    send_request(REQ_READ, DATA_W'($urandom_range(0, 255)),
                 IDX_W'($urandom_range(0, written_span - 1)));
  endtask

  // Sends one frame byte, sometimes preceded by a read or a tick that cannot discard.
  task automatic push_byte(input logic [DATA_W-1:0] data);
    if (filler_on && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0 && idle_seen + 1 < cur_timeout) begin
        send_request(REQ_TICK, DATA_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 511)));
      end else if (written_span > 0) begin
        send_read();
      end
    end
    send_request(REQ_BYTE, data, IDX_W'($urandom_range(0, 511)));
  endtask

  // Builds a frame with a random payload and a correct or broken CRC, then sends
  // its first nbytes bytes.
  task automatic send_frame(input logic [WORD_W-1:0] len_field, input int nbytes,
                            input bit bad_crc);
    logic [DATA_W-1:0] bytes_q [$];
    logic [WORD_W-1:0] crc;
    bytes_q = {};
    for (int i = 0; i < nbytes; i++) begin
      bytes_q.push_back(DATA_W'($urandom_range(0, 255)));
    end
    for (int i = 0; i < LEN_BYTES && i < nbytes; i++) begin
      bytes_q[i] = len_field[8*i +: 8];
    end
    crc = '1;
    for (int i = CRC_START; i < nbytes; i++) begin
      crc = crc32_step(crc, bytes_q[i]);
    end
    crc = ~crc;
    if (bad_crc) begin
      crc = crc ^ (32'h1 << $urandom_range(0, 31));
    end
    for (int i = LEN_BYTES; i < CRC_START && i < nbytes; i++) begin
      bytes_q[i] = crc[8*(i-LEN_BYTES) +: 8];
    end
    foreach (bytes_q[i]) begin
      push_byte(bytes_q[i]);
    end
  endtask

  // Ticks until the idle timeout throws the partial frame away.
  task automatic drain_idle();
    do begin
      send_request(REQ_TICK, DATA_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 511)));
    end while (idle_seen != 0);
  endtask

  // A few stray ticks, reads and requests of the unused kind between frames.
  task automatic send_noise(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 5);
      if (pick < 3) begin
        send_request(REQ_TICK, DATA_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 511)));
      end else if (pick < 5 && written_span > 0) begin
        send_read();
      end else begin
        send_request(REQ_UNUSED, DATA_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 511)));
      end
    end
  endtask

  // Stops offering requests until every predicted result has come out.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes the idle timeout register while the receiver is idle.
  task automatic set_idle_timeout(input int ticks);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= DATA_W'(ticks);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid   <= 1'b0;
    cur_timeout = ticks;
  endtask

  // One random sequence: mostly well-formed frames, some broken ones and some noise.
  task automatic random_sequence();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(12, 40);
    if (pick < 60) begin
      send_frame(len, len, 1'b0);
    end else if (pick < 75) begin
      send_frame(len, len, 1'b1);
    end else if (pick < 85) begin
      send_frame($urandom_range(0, HEADER_BYTES - 1), HEADER_BYTES, 1'b0);
    end else if (pick < 93 && cur_timeout <= 16) begin
      // A truncated frame with any declared length, cleared by the idle timeout.
      send_frame($urandom(), $urandom_range(1, HEADER_BYTES - 1), 1'b0);
      drain_idle();
    end else begin
      send_noise($urandom_range(1, 5));
    end
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_now  = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Request and register stimulus, then the verdict.
  initial begin
    in_valid      = 1'b0;
    in_req_type   = REQ_BYTE;
    in_rx_byte    = '0;
    in_read_index = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    gap_on        = 1'b0;
    stall_on      = 1'b0;
    filler_on     = 1'b0;
    hold_now      = 1'b0;
    timeout_plan  = '{1, 255, 0, $urandom_range(2, 254), TIMEOUT_RESET};
    phase_end     = '{700, 1000, 1650, 1800, ITEM_GOAL};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks on an empty fill reach the reset timeout and discard anyway.
    repeat (3) send_request(REQ_TICK, 8'h00, 9'h000);
    send_request(REQ_UNUSED, 8'hFF, 9'h1FF);
    // Declared length zero with an all-ones CRC and command word is too short.
    for (int i = 0; i < HEADER_BYTES; i++) begin
      push_byte(i < LEN_BYTES ? 8'h00 : 8'hFF);
    end
    send_request(REQ_READ, 8'hFF, 9'd0);
    send_request(REQ_READ, 8'h00, 9'd11);
    // The shortest legal frame.
    send_frame(HEADER_BYTES, HEADER_BYTES, 1'b0);

    for (int p = 0; p < 5; p++) begin
      set_idle_timeout(timeout_plan[p]);
      filler_on = 1'b1;
      gap_on    = (p < 4);
      stall_on  = (p < 4);
      case (p)
        0: begin
          // A frame that fills the whole buffer exactly.
          send_frame(BUFFER_BYTES_DEF, BUFFER_BYTES_DEF, 1'b0);
        end
        1: begin
          // The result side holds off while requests keep coming, so the input backs up.
          gap_on   = 1'b0;
          hold_now = 1'b1;
          send_frame(100, 100, 1'b0);
        end
        2: begin
          // Declared length beyond the buffer: bytes past the end are dropped and
          // only the idle timeout clears the fill.
          send_frame(BUFFER_BYTES_DEF + $urandom_range(1, 1000), BUFFER_BYTES_DEF + 8, 1'b0);
          drain_idle();
        end
        default: begin
        end
      endcase
      while (items_sent < phase_end[p]) begin
        if (p < 4) begin
          gap_on   = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        random_sequence();
      end
    end

    wait_quiet();
    $display("Sent %0d requests under idle timeouts 3, %0d, %0d, %0d, %0d and %0d.",
             items_sent, timeout_plan[0], timeout_plan[1], timeout_plan[2], timeout_plan[3],
             timeout_plan[4]);
    $display({"Checked %0d results: %0d frames accepted, %0d bad CRC, %0d too short,",
              " %0d idle discards, %0d reads over %0d buffer bytes."},
             results_checked, accepted_frames, crc_rejects, short_frames, idle_discards,
             buffer_reads, written_span);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_ram.sv
rtl/core/crcfr_ctrl.sv
rtl/core/crc_checked_frame_receiver_unit.sv
tb/sv/crcfr_result_checker.sv
tb/sv/tb_crc_checked_frame_receiver_unit.sv
